/* src/window_average_motion_detector_macros.svh */
// Assertion macros for the motion detector checker.
`ifndef WINDOW_AVERAGE_MOTION_DETECTOR_MACROS_SVH
`define WINDOW_AVERAGE_MOTION_DETECTOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WAMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define WAMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/wamd_pkg.sv */
// Shared types and constants of the window average motion detector.
`default_nettype none

package wamd_pkg;

  localparam int SAMPLE_W           = 24;
  localparam int FRAC_W             = 8;
  localparam int INT_W              = SAMPLE_W - FRAC_W;
  localparam int THRESH_W           = 15;
  localparam int MODE_W             = 2;
  localparam int DEV_W              = 18;
  localparam int WINDOW_LEN_DEFAULT = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd10;

  // Detector mode, also shown on the result beat.
  typedef enum logic [MODE_W-1:0] {
    MODE_STILL  = 2'd0,
    MODE_MOTION = 2'd1,
    MODE_SETTLE = 2'd2,
    MODE_DONE   = 2'd3
  } mode_e;

  // Window commands from the mode controller to the datapath.
  typedef struct packed {
    logic push;
    logic clear;
    logic slot_reset;
  } ctl_t;

endpackage

`default_nettype wire

/* src/window_average_motion_detector.sv */
// Top level of the window average motion detector.
// Input channel: in_valid_i / in_ready_o carry one signed Q16.8 sample_i per beat.
// Output channel: out_valid_o / out_ready_i carry one result beat per sample:
//   mode_o, window_average_o (window sum / WINDOW_LEN, toward zero) and
//   deviation_o (integer sample minus integer previous average, or zero).
// Configuration: cfg_we_i writes cfg_wdata_i into the motion threshold at once;
//   write it only while no sample is in flight.
// Path: input register, then one pass through the mode logic, window RAM
//   and average unit into the result register. Throughput: one sample per
//   cycle while results are taken.
// The window is a RAM of WINDOW_LEN entries whose old entry at the write slot
//   is prefetched each cycle; per-entry valid bits make cleared entries read 0.
// Reset: mode still, counters, sum and valid bits clear, threshold 10; no
//   memory sweep is needed, so samples are taken right after reset.
// Stall: a held result keeps its values; one more sample waits in the input
//   register, after which in_ready_o drops until the result is taken.
`default_nettype none

module window_average_motion_detector #(
  parameter int WINDOW_LEN = wamd_pkg::WINDOW_LEN_DEFAULT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [wamd_pkg::THRESH_W-1:0] cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [wamd_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic             [wamd_pkg::MODE_W-1:0]   mode_o,
  output logic signed      [wamd_pkg::SAMPLE_W-1:0] window_average_o,
  output logic signed      [wamd_pkg::DEV_W-1:0]    deviation_o
);

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = wamd_pkg::SAMPLE_W + IDX_W;
  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(WINDOW_LEN - 1);

  logic                                  s1_valid_q;
  logic signed [wamd_pkg::SAMPLE_W-1:0]  s1_sample_q;
  logic                                  fire;
  logic                                  out_valid_q;
  logic signed [wamd_pkg::DEV_W-1:0]     dev_q;
  logic [wamd_pkg::THRESH_W-1:0]         thresh_q;

  logic signed [SUM_W-1:0]               sum_q, sum_d;
  logic signed [wamd_pkg::SAMPLE_W-1:0]  avg_q, avg_d;
  logic [IDX_W-1:0]                      slot_q, slot_d;
  logic [WINDOW_LEN-1:0]                 valid_q;
  logic [wamd_pkg::SAMPLE_W-1:0]         ram_rdata;
  logic signed [wamd_pkg::SAMPLE_W-1:0]  old_sample;

  wamd_pkg::mode_e                       mode;
  logic signed [wamd_pkg::DEV_W-1:0]     dev;
  wamd_pkg::ctl_t                        ctl;

  // Move a beat from the input register into the result register.
  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  // Hold the motion threshold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= wamd_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Track input and result register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
    end
    if (fire) begin
      dev_q <= dev;
    end
  end

  wamd_ctrl #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .sample_i (s1_sample_q),
    .avg_i    (avg_q),
    .thresh_i (thresh_q),
    .mode_o   (mode),
    .dev_o    (dev),
    .ctl_o    (ctl)
  );

  // Drop entries that were cleared or never written.
  assign old_sample = valid_q[slot_q] ? ram_rdata : '0;

  // Update running sum and write slot.
  always_comb begin
    sum_d  = sum_q;
    slot_d = slot_q;
    if (fire) begin
      if (ctl.clear) begin
        sum_d = '0;
      end else if (ctl.push) begin
        sum_d = sum_q + SUM_W'(s1_sample_q) - SUM_W'(old_sample);
      end
      if (ctl.push) begin
        slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + IDX_W'(1);
      end else if (ctl.slot_reset) begin
        slot_d = '0;
      end
    end
  end

  wamd_avg_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_avg_div (
    .sum_i (sum_d),
    .avg_o (avg_d)
  );

  // Prefetch the entry at the next write slot.
  wamd_ram #(
    .WIDTH (wamd_pkg::SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (fire && ctl.push),
    .waddr_i (slot_q),
    .wdata_i (s1_sample_q),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  // Hold window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      avg_q   <= '0;
      slot_q  <= '0;
      valid_q <= '0;
    end else begin
      sum_q  <= sum_d;
      slot_q <= slot_d;
      if (fire) begin
        avg_q <= avg_d;
        if (ctl.clear) begin
          valid_q <= '0;
        end else if (ctl.push) begin
          valid_q[slot_q] <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_o           = mode;
  assign window_average_o = avg_q;
  assign deviation_o      = dev_q;

endmodule

`default_nettype wire

/* src/wamd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wamd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/wamd_avg_div.sv */
// Window average: running sum divided by the window length, toward zero.
`default_nettype none

module wamd_avg_div #(
  parameter int WINDOW_LEN = wamd_pkg::WINDOW_LEN_DEFAULT
) (
  input  wire logic signed [wamd_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0] sum_i,
  output logic signed      [wamd_pkg::SAMPLE_W-1:0]                    avg_o
);

  localparam int IDX_W   = $clog2(WINDOW_LEN);
  localparam int SUM_W   = wamd_pkg::SAMPLE_W + IDX_W;
  localparam int RECIP_W = wamd_pkg::SAMPLE_W + IDX_W;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // |sum| <= N * 2^23, so a shift of 23 + 2*clog2(N) keeps the quotient exact.
  localparam int SHIFT   = wamd_pkg::SAMPLE_W - 1 + 2 * IDX_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic                           sum_neg;
  logic [SUM_W-1:0]               sum_mag;
  logic [PROD_W-1:0]              prod;
  logic [wamd_pkg::SAMPLE_W-1:0]  quot;

  // Take the magnitude, scale by the reciprocal, restore the sign.
  assign sum_neg = sum_i[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign prod    = PROD_W'(sum_mag) * PROD_W'(RECIP);
  assign quot    = prod[SHIFT +: wamd_pkg::SAMPLE_W];
  assign avg_o   = sum_neg ? wamd_pkg::SAMPLE_W'(-quot) : quot;

endmodule

`default_nettype wire

/* src/wamd_ctrl.sv */
// Mode controller: learning, motion, settling counters and deviation test.
`default_nettype none

module wamd_ctrl #(
  parameter int WINDOW_LEN = wamd_pkg::WINDOW_LEN_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                fire_i,
  input  wire logic signed [wamd_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic signed [wamd_pkg::SAMPLE_W-1:0] avg_i,
  input  wire logic        [wamd_pkg::THRESH_W-1:0] thresh_i,
  output wamd_pkg::mode_e                           mode_o,
  output logic signed      [wamd_pkg::DEV_W-1:0]    dev_o,
  output wamd_pkg::ctl_t                            ctl_o
);

  localparam int LC_W = $clog2(WINDOW_LEN + 2);
  localparam int MC_W = $clog2(4 * WINDOW_LEN + 2);
  localparam int SC_W = $clog2(WINDOW_LEN + 1);
  localparam int DEV_W = wamd_pkg::DEV_W;
  localparam int INT_W = wamd_pkg::INT_W;

  localparam logic [LC_W-1:0] LEARN_N   = LC_W'(WINDOW_LEN);
  localparam logic [LC_W-1:0] LEARN_MAX = LC_W'(WINDOW_LEN + 1);
  localparam logic [MC_W-1:0] MOVE_2N   = MC_W'(2 * WINDOW_LEN);
  localparam logic [MC_W-1:0] MOVE_3N   = MC_W'(3 * WINDOW_LEN);
  localparam logic [MC_W-1:0] MOVE_4N   = MC_W'(4 * WINDOW_LEN);
  localparam logic [MC_W-1:0] MOVE_MAX  = MC_W'(4 * WINDOW_LEN + 1);
  localparam logic [SC_W-1:0] SETTLE_N  = SC_W'(WINDOW_LEN);

  // Integer part of a Q16.8 value, truncated toward zero.
  function automatic logic signed [INT_W-1:0] q8_int(
    input logic signed [wamd_pkg::SAMPLE_W-1:0] v
  );
    logic signed [INT_W-1:0] hi;
    hi = v[wamd_pkg::SAMPLE_W-1:wamd_pkg::FRAC_W];
    if (v[wamd_pkg::SAMPLE_W-1] && (v[wamd_pkg::FRAC_W-1:0] != '0)) begin
      hi = hi + INT_W'(1);
    end
    return hi;
  endfunction

  wamd_pkg::mode_e   mode_q, mode_d, trial_mode;
  logic [LC_W-1:0]   learn_q, learn_d;
  logic [MC_W-1:0]   move_q, move_d;
  logic [SC_W-1:0]   settle_q, settle_d, trial_settle;

  logic signed [DEV_W-1:0] dev;
  logic [DEV_W-1:0]        dev_mag;
  logic                    dev_gt, dev_lt;
  logic                    still, still_cmp, motion, moving_cmp, finish;

  // Compare integer parts of sample and previous average.
  assign dev     = DEV_W'(q8_int(sample_i)) - DEV_W'(q8_int(avg_i));
  assign dev_mag = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
  assign dev_gt  = dev_mag > DEV_W'(thresh_i);
  assign dev_lt  = dev_mag < DEV_W'(thresh_i);

  assign still      = mode_q inside {wamd_pkg::MODE_STILL, wamd_pkg::MODE_DONE};
  assign still_cmp  = still && (learn_q > LEARN_N);
  assign motion     = still_cmp && dev_gt;
  assign moving_cmp = !still && (move_q >= MOVE_2N);

  // Work out the settling outcome of a compared moving-phase beat.
  always_comb begin
    trial_mode   = mode_q;
    trial_settle = settle_q;
    if (move_q > MOVE_4N) begin
      if (dev_lt) begin
        trial_mode = wamd_pkg::MODE_SETTLE;
        if (settle_q != SETTLE_N) begin
          trial_settle = settle_q + SC_W'(1);
        end
      end
      if (dev_gt) begin
        trial_mode   = wamd_pkg::MODE_MOTION;
        trial_settle = '0;
      end
    end
  end

  assign finish = moving_cmp && (trial_mode == wamd_pkg::MODE_SETTLE) &&
                  (trial_settle == SETTLE_N);

  // Next state: mode and counters.
  always_comb begin
    mode_d   = mode_q;
    learn_d  = learn_q;
    move_d   = move_q;
    settle_d = settle_q;
    if (still) begin
      if (motion) begin
        mode_d = wamd_pkg::MODE_MOTION;
      end else if (learn_q != LEARN_MAX) begin
        learn_d = learn_q + LC_W'(1);
      end
    end else if (!moving_cmp) begin
      move_d = move_q + MC_W'(1);
    end else if (finish) begin
      mode_d   = wamd_pkg::MODE_DONE;
      move_d   = '0;
      settle_d = '0;
    end else begin
      mode_d   = trial_mode;
      settle_d = trial_settle;
      if (move_q != MOVE_MAX) begin
        move_d = move_q + MC_W'(1);
      end
    end
  end

  // Outputs: window commands and reported deviation.
  always_comb begin
    ctl_o.slot_reset = motion;
    ctl_o.clear      = moving_cmp && !finish && (move_q == MOVE_3N);
    if (still) begin
      ctl_o.push = !motion;
    end else begin
      ctl_o.push = moving_cmp && !finish && (move_q > MOVE_3N);
    end
    dev_o = (still_cmp || moving_cmp) ? dev : '0;
  end

  // Advance state on each processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= wamd_pkg::MODE_STILL;
      learn_q  <= '0;
      move_q   <= '0;
      settle_q <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      learn_q  <= learn_d;
      move_q   <= move_d;
      settle_q <= settle_d;
    end
  end

  assign mode_o = mode_q;

endmodule

`default_nettype wire

/* src/wamd_checker.sv */
// Port-level checker for the window average motion detector, bound to the top.
`default_nettype none

`include "window_average_motion_detector_macros.svh"

module wamd_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic        [wamd_pkg::MODE_W-1:0]   mode_o,
  input wire logic signed [wamd_pkg::SAMPLE_W-1:0] window_average_o,
  input wire logic signed [wamd_pkg::DEV_W-1:0]    deviation_o
);

  // Hold a stalled result beat.
  `WAMD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(mode_o) && $stable(window_average_o) && $stable(deviation_o), "result beat changed while stalled")

  // A fresh result has a matching input beat, taken through the input register.
  `WAMD_ASSERT(a_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2), "result without matching input beat")

  // Take input whenever the result register is empty.
  `WAMD_ASSERT(a_ready_empty, !out_valid_o |-> in_ready_o, "input stalled with empty result register")

  // Show no result right after reset.
  `WAMD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind window_average_motion_detector wamd_checker u_wamd_checker (.*);

`default_nettype wire

/* tb/window_average_motion_detector_test.sv */
// Self-checking testbench of the window average motion detector with a cycle-free mode predictor.
module window_average_motion_detector_test;

  localparam int WIN = wamd_pkg::WINDOW_LEN_DEFAULT;

  typedef struct packed {
    logic [wamd_pkg::MODE_W-1:0]          mode;
    logic signed [wamd_pkg::SAMPLE_W-1:0] avg;
    logic signed [wamd_pkg::DEV_W-1:0]    dev;
  } motion_result_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [wamd_pkg::THRESH_W-1:0]        cfg_wdata_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic signed [wamd_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [wamd_pkg::MODE_W-1:0]          mode_o;
  logic signed [wamd_pkg::SAMPLE_W-1:0] window_average_o;
  logic signed [wamd_pkg::DEV_W-1:0]    deviation_o;

  window_average_motion_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mode_o          (mode_o),
    .window_average_o(window_average_o),
    .deviation_o     (deviation_o)
  );

  // Predictor state, a private copy of the detector
  logic signed [wamd_pkg::SAMPLE_W-1:0] win_q [WIN];
  longint                               win_sum = 0;
  int unsigned                          slot = 0;
  int unsigned                          learned = 0;
  int unsigned                          moved = 0;
  int unsigned                          settled = 0;
  wamd_pkg::mode_e                      det_mode = wamd_pkg::MODE_STILL;
  logic [wamd_pkg::THRESH_W-1:0]        thr_q = wamd_pkg::THRESH_RESET;

  // Stimulus and scoreboard
  logic signed [wamd_pkg::SAMPLE_W-1:0] sample_todo_q [$];
  motion_result_t                       result_due_q [$];
  int unsigned                          samples_queued = 0;
  int unsigned                          samples_taken = 0;
  int unsigned                          results_checked = 0;
  int unsigned                          settings_used = 0;
  int unsigned                          fail_count = 0;
  int unsigned                          send_gap_pct = 12;
  int unsigned                          recv_gap_pct = 62;
  bit                                   sample_taken = 1'b0;
  bit [3:0]                             modes_seen = '0;

  initial begin
    for (int i = 0; i < WIN; i++) win_q[i] = '0;
  end

  // Free-running clock, period 20
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Overwrite the oldest window slot and keep the sum exact
  task automatic push_window(input longint s);
    int unsigned k;
    k = slot % WIN;
    win_sum += s - longint'(win_q[k]);
    win_q[k] = s[wamd_pkg::SAMPLE_W-1:0];
    slot = (k + 1) % WIN;
  endtask

  // Advance the predicted detector by one sample and return its result beat
  task automatic detect_motion(input logic signed [wamd_pkg::SAMPLE_W-1:0] smp,
                               output motion_result_t res);
    longint s, dev, thr, mg;
    bit keep, done;
    s = longint'(smp);
    dev = 0;
    thr = longint'(thr_q);
    if (det_mode == wamd_pkg::MODE_STILL || det_mode == wamd_pkg::MODE_DONE) begin
      keep = 1'b1;
      if (learned > WIN) begin
        dev = s / 256 - (win_sum / WIN) / 256;
        mg = dev < 0 ? -dev : dev;
        // Motion: drop the sample and restart the slot pointer
        if (mg > thr) begin
          det_mode = wamd_pkg::MODE_MOTION;
          slot = 0;
          keep = 1'b0;
        end
      end
      if (keep) begin
        if (learned < WIN + 1) learned++;
        push_window(s);
      end
    end else if (moved < 2 * WIN) begin
      moved++;
    end else begin
      done = 1'b0;
      dev = s / 256 - (win_sum / WIN) / 256;
      mg = dev < 0 ? -dev : dev;
      // Settle on in-threshold samples, restart on an excursion, hold on equality
      if (moved > 4 * WIN) begin
        if (mg < thr) begin
          det_mode = wamd_pkg::MODE_SETTLE;
          if (settled < WIN) settled++;
        end
        if (mg > thr) begin
          det_mode = wamd_pkg::MODE_MOTION;
          settled = 0;
        end
      end
      if (det_mode == wamd_pkg::MODE_SETTLE && settled >= WIN) begin
        det_mode = wamd_pkg::MODE_DONE;
        moved = 0;
        settled = 0;
        done = 1'b1;
      end
      if (!done) begin
        // Clear the window at 3N, refill it after that
        if (moved == 3 * WIN) begin
          for (int i = 0; i < WIN; i++) win_q[i] = '0;
          win_sum = 0;
        end
        if (moved > 3 * WIN) push_window(s);
        if (moved < 4 * WIN + 1) moved++;
      end
    end
    res.mode = det_mode;
    res.avg = wamd_pkg::SAMPLE_W'(win_sum / WIN);
    res.dev = wamd_pkg::DEV_W'(dev);
  endtask

  // Driver: present samples from the pending queue, gap and stall at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (!in_valid_i || sample_taken) begin
        if (sample_todo_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          sample_i <= sample_todo_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          sample_i <= wamd_pkg::SAMPLE_W'($urandom);
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_gap_pct;
    end
  end

  // Monitor: check each result beat, then predict for each accepted sample
  always @(posedge clk_i) begin
    motion_result_t want;
    if (rst_ni) begin
      sample_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        modes_seen[mode_o] = 1'b1;
        if (result_due_q.size() == 0) begin
          $error("result beat with no sample pending");
          fail_count++;
        end else begin
          want = result_due_q.pop_front();
          if (mode_o !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, mode_o);
            fail_count++;
          end
          if (window_average_o !== want.avg) begin
            $error("window_average: expected %0d, got %0d", want.avg, window_average_o);
            fail_count++;
          end
          if (deviation_o !== want.dev) begin
            $error("deviation: expected %0d, got %0d", want.dev, deviation_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        detect_motion(sample_i, want);
        result_due_q.push_back(want);
        samples_taken++;
      end
    end
  end

  task automatic queue_sample(input logic signed [wamd_pkg::SAMPLE_W-1:0] s);
    sample_todo_q.push_back(s);
    samples_queued++;
  endtask

  // Sample near an integer level; the fraction never moves the integer part
  function automatic logic signed [wamd_pkg::SAMPLE_W-1:0] calm_value(input int base_int);
    int f;
    f = $urandom_range(255);
    return wamd_pkg::SAMPLE_W'(base_int >= 0 ? base_int * 256 + f : base_int * 256 - f);
  endfunction

  // One motion episode: calm lead-in, a spike, then a long calm stretch that
  // skips, clears, refills and settles; noise early, threshold-equal hits late
  task automatic queue_episode(input bit extreme, input int tail);
    int thr, span, base_int, spike_int, r, lead;
    logic signed [wamd_pkg::SAMPLE_W-1:0] level, spike;
    thr = int'(thr_q);
    span = 32767 - thr;
    base_int = int'($urandom_range(2 * span)) - span;
    if (base_int >= 0) begin
      r = $urandom_range((base_int - thr - 1 + 32768) < 1000 ?
                         (base_int - thr - 1 + 32768) : 1000);
      spike_int = base_int - thr - 1 - r;
    end else begin
      r = $urandom_range((32767 - base_int - thr - 1) < 1000 ?
                         (32767 - base_int - thr - 1) : 1000);
      spike_int = base_int + thr + 1 + r;
    end
    spike = wamd_pkg::SAMPLE_W'(spike_int * 256);
    level = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    if (extreme) spike = ~level;
    lead = extreme ? WIN : $urandom_range(6, 12);
    for (int k = 0; k < lead; k++) begin
      if (extreme) queue_sample(level);
      else if ($urandom_range(7) == 0) queue_sample(wamd_pkg::SAMPLE_W'($urandom));
      else queue_sample(calm_value(base_int));
    end
    queue_sample(spike);
    for (int k = 0; k < tail; k++) begin
      if (extreme) begin
        queue_sample(level);
      end else if (k < 30 && $urandom_range(7) == 0) begin
        queue_sample(wamd_pkg::SAMPLE_W'($urandom));
      end else begin
        if (k >= 66 && $urandom_range(5) == 0)
          queue_sample(wamd_pkg::SAMPLE_W'(
            ($urandom_range(1) ? base_int + thr : base_int - thr) * 256));
        queue_sample(calm_value(base_int));
      end
    end
    // Full window at one extreme, then the other: widest deviation
    if (extreme) queue_sample(spike);
  endtask

  // Wait until every queued sample has been taken and answered
  task automatic wait_quiet();
    while (samples_taken != samples_queued || result_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [wamd_pkg::THRESH_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    thr_q = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= wamd_pkg::THRESH_W'($urandom);
    settings_used++;
    @(posedge clk_i);
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and signed truncation while learning with the
    // reset threshold, then a first comparison that triggers, then skips
    queue_sample(24'sh800000);
    queue_sample(24'sh7FFFFF);
    queue_sample(24'sd0);
    queue_sample(-24'sd1);
    queue_sample(24'sd1);
    queue_sample(24'sd255);
    queue_sample(-24'sd255);
    queue_sample(24'sd256);
    queue_sample(-24'sd256);
    queue_sample(-24'sd257);
    for (int k = 0; k < 7; k++) queue_sample(24'sd0);
    queue_sample(24'sd0);
    queue_sample(24'sh7FFFFF);
    queue_sample(24'sh800000);
    settings_used++;
    wait_quiet();

    // Largest threshold, extreme levels
    write_threshold(15'd32767);
    queue_episode(1'b1, $urandom_range(84, 92));
    wait_quiet();

    write_threshold(wamd_pkg::THRESH_W'($urandom_range(16, 3000)));
    queue_episode(1'b0, $urandom_range(84, 92));
    wait_quiet();

    // Swap the gap rates
    write_threshold(15'd0);
    send_gap_pct = 62;
    recv_gap_pct = 12;
    // Zero threshold: motion never settles
    queue_episode(1'b0, 40);
    wait_quiet();

    write_threshold(wamd_pkg::THRESH_W'($urandom_range(1, 8)));
    queue_episode(1'b0, $urandom_range(84, 92));
    wait_quiet();

    // No gaps on either side
    write_threshold(wamd_pkg::THRESH_W'($urandom_range(100, 20000)));
    send_gap_pct = 0;
    recv_gap_pct = 0;
    queue_episode(1'b0, $urandom_range(84, 92));
    wait_quiet();

    repeat (20) @(posedge clk_i);
    if (result_due_q.size() != 0) begin
      $error("%0d expected results never arrived", result_due_q.size());
      fail_count++;
    end
    $display("Summary: %0d samples over %0d threshold settings, %0d result beats checked",
             samples_taken, settings_used, results_checked);
    $display("Summary: detector modes reached (bit per mode) %b", modes_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
